FILE: hw/rtl/pmpre_pkg.sv
// Shared types and constants for the PMP region encoder pipeline.
package pmpre_pkg;

    localparam int XLEN  = 64;
    localparam int IDX_W = 6;
    localparam int CSR_W = 12;

    localparam logic [CSR_W-1:0] ADDR_CSR_BASE = 12'h3B0;
    localparam logic [CSR_W-1:0] CFG_CSR_BASE  = 12'h3A0;

    localparam int PERM_R_BIT = 0;
    localparam int PERM_W_BIT = 1;

    localparam logic [7:0] MODE_NA4   = 8'h10;
    localparam logic [7:0] MODE_NAPOT = 8'h18;

    // First stage result: early checks done, size decremented.
    typedef struct packed {
        logic            valid;
        logic            early_bad;
        logic            whole_space;
        logic            size_small;
        logic [IDX_W-1:0] idx;
        logic [2:0]      perm;
        logic [XLEN-1:0] start;
        logic [XLEN-1:0] size;
        logic [XLEN-1:0] size_m1;
        logic [XLEN-1:0] cfg_word;
    } t_s1;

    // Second stage result: region verdict and encoded address.
    typedef struct packed {
        logic            valid;
        logic            rejected;
        logic            na4;
        logic [IDX_W-1:0] idx;
        logic [2:0]      perm;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] cfg_word;
    } t_s2;

endpackage

FILE: hw/rtl/pmpre_decode.sv
// First pipeline stage: index and permission checks, size decrement.
module pmpre_decode #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic signed [7:0]      i_entry_index,
    input  logic [63:0]            i_region_start,
    input  logic [63:0]            i_region_size,
    input  logic [7:0]             i_permissions,
    input  logic [63:0]            i_current_cfg_word,
    output pmpre_pkg::t_s1         o_s1
);
    import pmpre_pkg::*;

    t_s1  r_s1;
    t_s1  n_s1;
    logic idx_ok;
    logic perm_ok;

    always_comb begin
        idx_ok  = !i_entry_index[7] && (i_entry_index[6:0] < 7'(NUM_ENTRIES));
        // Write without read is a reserved combination.
        perm_ok = (i_permissions[7:3] == 5'd0) &&
                  !(i_permissions[PERM_W_BIT] && !i_permissions[PERM_R_BIT]);

        n_s1.valid       = i_accept;
        n_s1.early_bad   = !(idx_ok && perm_ok);
        n_s1.whole_space = (i_region_start == '0) && (i_region_size == '1);
        n_s1.size_small  = (i_region_size[XLEN-1:2] == '0);
        n_s1.idx         = i_entry_index[IDX_W-1:0];
        n_s1.perm        = i_permissions[2:0];
        n_s1.start       = i_region_start;
        n_s1.size        = i_region_size;
        n_s1.size_m1     = i_region_size - 64'd1;
        n_s1.cfg_word    = i_current_cfg_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

FILE: hw/rtl/pmpre_check.sv
// Second pipeline stage: power-of-two, alignment and wrap checks, address encode.
module pmpre_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmpre_pkg::t_s1  i_s1,
    output pmpre_pkg::t_s2  o_s2
);
    import pmpre_pkg::*;

    t_s2             r_s2;
    t_s2             n_s2;
    logic [XLEN:0]   end_sum;
    logic            region_bad;
    logic [XLEN-1:0] napot_addr;

    always_comb begin
        // A carry out of base plus size minus one means the region wraps.
        end_sum    = {1'b0, i_s1.start} + {1'b0, i_s1.size_m1};
        region_bad = i_s1.size_small ||
                     ((i_s1.size & i_s1.size_m1) != '0) ||
                     ((i_s1.start & i_s1.size_m1) != '0) ||
                     end_sum[XLEN];
        // Clear the granule bits covered by the size, then set all but the top one.
        napot_addr = ((i_s1.start >> 2) & ~(i_s1.size_m1 >> 2)) | (i_s1.size_m1 >> 3);

        n_s2.valid    = i_s1.valid;
        n_s2.rejected = i_s1.early_bad || (!i_s1.whole_space && region_bad);
        n_s2.na4      = !i_s1.whole_space && (i_s1.size_m1 == 64'd3);
        n_s2.idx      = i_s1.idx;
        n_s2.perm     = i_s1.perm;
        n_s2.addr     = i_s1.whole_space ? '1 : napot_addr;
        n_s2.cfg_word = i_s1.cfg_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

FILE: hw/rtl/pmpre_merge.sv
// Third pipeline stage: config byte merge, CSR numbers and the output register.
module pmpre_merge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmpre_pkg::t_s2  i_s2,
    output logic            o_valid,
    output logic            o_rejected,
    output logic [11:0]     o_addr_reg_number,
    output logic [63:0]     o_addr_value,
    output logic [11:0]     o_cfg_reg_number,
    output logic [63:0]     o_cfg_value
);
    import pmpre_pkg::*;

    logic             r_valid;
    logic             r_rejected;
    logic [CSR_W-1:0] r_addr_reg;
    logic [XLEN-1:0]  r_addr;
    logic [CSR_W-1:0] r_cfg_reg;
    logic [XLEN-1:0]  r_cfg;

    logic [CSR_W-1:0] n_addr_reg;
    logic [XLEN-1:0]  n_addr;
    logic [CSR_W-1:0] n_cfg_reg;
    logic [XLEN-1:0]  n_cfg;
    logic [7:0]       cfg_byte;
    logic [XLEN-1:0]  merged;
    logic [CSR_W-1:0] cfg_sum;

    always_comb begin
        cfg_byte = {5'd0, i_s2.perm} | (i_s2.na4 ? MODE_NA4 : MODE_NAPOT);
        for (int b = 0; b < XLEN / 8; b++) begin
            merged[b*8 +: 8] = (i_s2.idx[2:0] == 3'(b)) ? cfg_byte : i_s2.cfg_word[b*8 +: 8];
        end
        // Packed config registers are the even numbers only.
        cfg_sum = CFG_CSR_BASE + {{(CSR_W-IDX_W+2){1'b0}}, i_s2.idx[IDX_W-1:2]};

        if (i_s2.rejected) begin
            n_addr_reg = '0;
            n_addr     = '0;
            n_cfg_reg  = '0;
            n_cfg      = '0;
        end else begin
            n_addr_reg = ADDR_CSR_BASE + {{(CSR_W-IDX_W){1'b0}}, i_s2.idx};
            n_addr     = i_s2.addr;
            n_cfg_reg  = {cfg_sum[CSR_W-1:1], 1'b0};
            n_cfg      = merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
        end
        r_rejected <= i_s2.rejected;
        r_addr_reg <= n_addr_reg;
        r_addr     <= n_addr;
        r_cfg_reg  <= n_cfg_reg;
        r_cfg      <= n_cfg;
    end

    assign o_valid           = r_valid;
    assign o_rejected        = r_rejected;
    assign o_addr_reg_number = r_addr_reg;
    assign o_addr_value      = r_addr;
    assign o_cfg_reg_number  = r_cfg_reg;
    assign o_cfg_value       = r_cfg;

endmodule

FILE: hw/rtl/pmp_region_encoder_top.sv
// Top level of the PMP region encoder: three register stages, one word per cycle.
// A word accepted at a clock edge goes through the decode, check and merge registers in that
// order to the result ports, where the receiver takes it.
// Throughput: one word per cycle; busy stays low, so start is taken every cycle.
// The three pipeline stages (decode, check, merge) set the latency.
// Synchronous active-low reset clears all stage valid bits; the receiver cannot stall.
module pmp_region_encoder_top #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] i_entry_index,
    input  logic [63:0]       i_region_start,
    input  logic [63:0]       i_region_size,
    input  logic [7:0]        i_permissions,
    input  logic [63:0]       i_current_cfg_word,
    output logic              o_valid,
    output logic              o_rejected,
    output logic [11:0]       o_addr_reg_number,
    output logic [63:0]       o_addr_value,
    output logic [11:0]       o_cfg_reg_number,
    output logic [63:0]       o_cfg_value
);
    import pmpre_pkg::*;

    t_s1  s1;
    t_s2  s2;
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pmpre_decode #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_decode (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_entry_index      (i_entry_index),
        .i_region_start     (i_region_start),
        .i_region_size      (i_region_size),
        .i_permissions      (i_permissions),
        .i_current_cfg_word (i_current_cfg_word),
        .o_s1               (s1)
    );

    pmpre_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    pmpre_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s2              (s2),
        .o_valid           (o_valid),
        .o_rejected        (o_rejected),
        .o_addr_reg_number (o_addr_reg_number),
        .o_addr_value      (o_addr_value),
        .o_cfg_reg_number  (o_cfg_reg_number),
        .o_cfg_value       (o_cfg_value)
    );

endmodule

FILE: hw/rtl/pmpre_checker.sv
// Port-level checker for the PMP region encoder and its bind to the top level.
module pmpre_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              i_busy,
    input logic signed [7:0] i_entry_index,
    input logic              i_valid,
    input logic              i_rejected,
    input logic [11:0]       i_addr_reg_number,
    input logic [63:0]       i_addr_value,
    input logic [11:0]       i_cfg_reg_number,
    input logic [63:0]       i_cfg_value
);

    // Every accepted word comes out as a result strobe, and nothing else does.
    a_latency: assert property (@(posedge i_clk)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)) |->
        (i_valid == $past(i_start && !i_busy, 3)))
        else $error("result strobe does not match accepted word three cycles back");

    // A negative entry index must always be rejected.
    a_neg_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && $past(i_start && !i_busy && i_entry_index[7], 3)) |-> i_rejected)
        else $error("negative entry index was not rejected");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_rejected) |->
        (i_addr_reg_number == 12'h000 && i_addr_value == 64'd0 &&
         i_cfg_reg_number == 12'h000 && i_cfg_value == 64'd0))
        else $error("rejected word carries nonzero fields");

    // Accepted words address the PMP CSR ranges, with an even config register.
    a_csr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_rejected) |->
        (i_cfg_reg_number[0] == 1'b0 && i_addr_reg_number >= 12'h3B0 &&
         i_cfg_reg_number >= 12'h3A0 && i_cfg_reg_number < 12'h3B0))
        else $error("CSR number out of the PMP range");

endmodule

bind pmp_region_encoder_top pmpre_checker u_pmpre_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (start),
    .i_busy            (busy),
    .i_entry_index     (i_entry_index),
    .i_valid           (o_valid),
    .i_rejected        (o_rejected),
    .i_addr_reg_number (o_addr_reg_number),
    .i_addr_value      (o_addr_value),
    .i_cfg_reg_number  (o_cfg_reg_number),
    .i_cfg_value       (o_cfg_value)
);

FILE: tb/pmp_region_checker.sv
// Checker for the PMP region encoder: predicts each result word and compares it.
`timescale 1ns / 100ps

module pmp_region_checker #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic signed [7:0] i_entry_index,
    input  logic [63:0]       i_region_start,
    input  logic [63:0]       i_region_size,
    input  logic [7:0]        i_permissions,
    input  logic [63:0]       i_current_cfg_word,
    input  logic              i_valid,
    input  logic              i_rejected,
    input  logic [11:0]       i_addr_reg_number,
    input  logic [63:0]       i_addr_value,
    input  logic [11:0]       i_cfg_reg_number,
    input  logic [63:0]       i_cfg_value,
    output int                o_fail_count,
    output int                o_pending_words
);

    typedef struct packed {
        logic        rejected;
        logic [11:0] addr_reg;
        logic [63:0] addr_value;
        logic [11:0] cfg_csr;
        logic [63:0] cfg_value;
    } t_region_result;

    t_region_result pending_results[$];
    int             mismatch_total = 0;

    function automatic t_region_result encode_region(
        input logic signed [7:0] idx,
        input logic [63:0]       base,
        input logic [63:0]       size,
        input logic [7:0]        perm,
        input logic [63:0]       cfg
    );
        t_region_result res;
        int             sidx;
        int             order;
        logic           whole_space;
        logic [63:0]    addr;
        logic [63:0]    m;
        logic [63:0]    byte_mask;
        logic [7:0]     cfg_byte;
        logic [5:0]     shift;

        res          = '0;
        res.rejected = 1'b1;
        sidx         = int'(idx);
        if (sidx < 0 || sidx >= NUM_ENTRIES)
            return res;
        if (perm[7:3] != 5'd0 || (perm[pmpre_pkg::PERM_W_BIT] && !perm[pmpre_pkg::PERM_R_BIT]))
            return res;

        whole_space = (base == 64'd0) && (size == '1);
        order       = 0;
        if (whole_space) begin
            order = pmpre_pkg::XLEN;
        end else begin
            if (size < 64'd4 || (size & (size - 64'd1)) != 64'd0 ||
                (base & (size - 64'd1)) != 64'd0 || base > ('1 - (size - 64'd1)))
                return res;
            for (int b = 0; b < 64; b++)
                if (size[b])
                    order = b;
        end

        // NAPOT: clear the low bits covered by the region, then fill all but the top one.
        addr = base >> 2;
        if (order > 2) begin
            if (order >= pmpre_pkg::XLEN) begin
                addr = '1;
            end else begin
                m    = (64'd1 << (order - 2)) - 64'd1;
                addr = (addr & ~m) | (m >> 1);
            end
        end

        cfg_byte  = perm | ((order == 2) ? pmpre_pkg::MODE_NA4 : pmpre_pkg::MODE_NAPOT);
        shift     = {idx[2:0], 3'b000};
        byte_mask = 64'hFF << shift;

        res.rejected   = 1'b0;
        res.addr_reg   = pmpre_pkg::ADDR_CSR_BASE + 12'(sidx);
        res.addr_value = addr;
        res.cfg_csr    = (pmpre_pkg::CFG_CSR_BASE + 12'(sidx >> 2)) & ~12'd1;
        res.cfg_value  = (cfg & ~byte_mask) | ((64'(cfg_byte) << shift) & byte_mask);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_region_result want;
        if (i_rst_n) begin
            // Compare before queuing, so a stray result cannot match this edge's word.
            if (i_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", i_addr_value, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_rejected !== want.rejected)
                        report_mismatch("rejected", 64'(i_rejected), 64'(want.rejected));
                    if (i_addr_reg_number !== want.addr_reg)
                        report_mismatch("addr_reg_number", 64'(i_addr_reg_number),
                                        64'(want.addr_reg));
                    if (i_addr_value !== want.addr_value)
                        report_mismatch("addr_value", i_addr_value, want.addr_value);
                    if (i_cfg_reg_number !== want.cfg_csr)
                        report_mismatch("cfg_reg_number", 64'(i_cfg_reg_number),
                                        64'(want.cfg_csr));
                    if (i_cfg_value !== want.cfg_value)
                        report_mismatch("cfg_value", i_cfg_value, want.cfg_value);
                end
            end
            if (i_start && !i_busy)
                pending_results.push_back(encode_region(i_entry_index, i_region_start,
                                                        i_region_size, i_permissions,
                                                        i_current_cfg_word));
        end
        o_pending_words <= pending_results.size();
        o_fail_count    <= mismatch_total;
    end

endmodule

FILE: tb/pmp_region_encoder_top_test.sv
// Testbench top for the PMP region encoder: reset, directed and random request words, verdict.
`timescale 1ns / 100ps

module pmp_region_encoder_top_test;

    localparam int NUM_ENTRIES  = 16;
    localparam int RANDOM_WORDS = 1600;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic              i_clk;
    logic              i_rst_n            = 1'b0;
    logic              start              = 1'b0;
    logic              busy;
    logic signed [7:0] i_entry_index      = '0;
    logic [63:0]       i_region_start     = '0;
    logic [63:0]       i_region_size      = '0;
    logic [7:0]        i_permissions      = '0;
    logic [63:0]       i_current_cfg_word = '0;
    logic              o_valid;
    logic              o_rejected;
    logic [11:0]       o_addr_reg_number;
    logic [63:0]       o_addr_value;
    logic [11:0]       o_cfg_reg_number;
    logic [63:0]       o_cfg_value;

    int fail_count;
    int pending_words;
    int stall_cycles = 0;

    pmp_region_encoder_top #(.NUM_ENTRIES(NUM_ENTRIES)) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_entry_index      (i_entry_index),
        .i_region_start     (i_region_start),
        .i_region_size      (i_region_size),
        .i_permissions      (i_permissions),
        .i_current_cfg_word (i_current_cfg_word),
        .o_valid            (o_valid),
        .o_rejected         (o_rejected),
        .o_addr_reg_number  (o_addr_reg_number),
        .o_addr_value       (o_addr_value),
        .o_cfg_reg_number   (o_cfg_reg_number),
        .o_cfg_value        (o_cfg_value)
    );

    pmp_region_checker #(.NUM_ENTRIES(NUM_ENTRIES)) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_entry_index      (i_entry_index),
        .i_region_start     (i_region_start),
        .i_region_size      (i_region_size),
        .i_permissions      (i_permissions),
        .i_current_cfg_word (i_current_cfg_word),
        .i_valid            (o_valid),
        .i_rejected         (o_rejected),
        .i_addr_reg_number  (o_addr_reg_number),
        .i_addr_value       (o_addr_value),
        .i_cfg_reg_number   (o_cfg_reg_number),
        .i_cfg_value        (o_cfg_value),
        .o_fail_count       (fail_count),
        .o_pending_words    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The watchdog restarts whenever a request or a result word moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_word(input logic [7:0] idx, input logic [63:0] base,
                             input logic [63:0] size, input logic [7:0] perm,
                             input logic [63:0] cfg);
        start              <= 1'b1;
        i_entry_index      <= idx;
        i_region_start     <= base;
        i_region_size      <= size;
        i_permissions      <= perm;
        i_current_cfg_word <= cfg;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_word();
        logic [7:0]  idx;
        logic [7:0]  perm;
        logic [63:0] base;
        logic [63:0] size;
        int          k;
        int          pick;

        // Most words are well-formed regions; the rest break one rule or are pure noise.
        pick = $urandom_range(0, 99);
        idx  = 8'($urandom_range(0, NUM_ENTRIES - 1));
        k    = $urandom_range(2, 63);
        size = 64'd1 << k;
        base = rand64() & ~(size - 64'd1);
        perm = 8'($urandom_range(0, 7));
        if (perm[1])
            perm[0] = 1'b1;
        if (pick < 5) begin
            base = '0;
            size = '1;
        end else if (pick < 10) begin
            idx = 8'($urandom_range(0, 255));
        end else if (pick < 14) begin
            perm = 8'($urandom_range(0, 255));
        end else if (pick < 18) begin
            base = base | (64'd1 << $urandom_range(0, k - 1));
        end else if (pick < 21) begin
            size = 64'($urandom_range(0, 7));
        end else if (pick < 25) begin
            idx  = 8'($urandom_range(0, 255));
            perm = 8'($urandom_range(0, 255));
            base = rand64();
            size = rand64();
        end
        send_word(idx, base, size, perm, rand64());
    endtask

    initial begin
        int burst_left;
        int gap;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Four-byte regions at both ends of the address space.
        send_word(8'd0, 64'd0, 64'd4, 8'h01, rand64());
        send_word(8'd15, 64'hFFFF_FFFF_FFFF_FFFC, 64'd4, 8'h07, rand64());
        // Entry indexes out of range, negative ones included.
        send_word(8'h80, 64'd0, 64'd4, 8'h01, rand64());
        send_word(8'hFF, 64'd0, 64'd4, 8'h01, rand64());
        send_word(8'd16, 64'd0, 64'd4, 8'h01, rand64());
        send_word(8'h7F, 64'd0, 64'd4, 8'h01, rand64());
        // Stray permission bits and write without read.
        send_word(8'd3, 64'd0, 64'd4, 8'h08, rand64());
        send_word(8'd3, 64'd0, 64'd4, 8'h80, rand64());
        send_word(8'd3, 64'd0, 64'd4, 8'h02, rand64());
        send_word(8'd3, 64'd0, 64'd4, 8'h06, rand64());
        // The remaining legal permission sets, spread over both config words.
        send_word(8'd8, 64'd8, 64'd8, 8'h03, rand64());
        send_word(8'd9, 64'h100, 64'h100, 8'h05, rand64());
        send_word(8'd12, 64'h40, 64'h20, 8'h04, rand64());
        send_word(8'd7, 64'h1000, 64'h1000, 8'h00, rand64());
        // Sizes that are too small or not a power of two, and a misaligned base.
        send_word(8'd1, 64'd0, 64'd0, 8'h01, rand64());
        send_word(8'd1, 64'd0, 64'd1, 8'h01, rand64());
        send_word(8'd1, 64'd0, 64'd2, 8'h01, rand64());
        send_word(8'd1, 64'd0, 64'd3, 8'h01, rand64());
        send_word(8'd1, 64'd0, 64'd6, 8'h01, rand64());
        send_word(8'd1, 64'd4, 64'd8, 8'h01, rand64());
        // Largest NAPOT regions, allow-all with good and bad permissions, then a full size at a nonzero base.
        send_word(8'd2, 64'd0, 64'h8000_0000_0000_0000, 8'h07, rand64());
        send_word(8'd6, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 8'h01, rand64());
        send_word(8'd5, 64'd0, '1, 8'h07, rand64());
        send_word(8'd5, 64'd0, '1, 8'h02, rand64());
        send_word(8'd4, 64'h1000, '1, 8'h07, rand64());
        wait_for_results();

        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2)
                wait_for_results();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            send_random_word();
            burst_left--;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
